// ----- rtl/core/key_value_table_top_defines.svh -----
// Assertion macros for the key/value table. Define ASSERT_OFF to drop them.
`ifndef KEY_VALUE_TABLE_TOP_DEFINES_SVH
`define KEY_VALUE_TABLE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define KVT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("key_value_table: check failed");
`define KVT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("key_value_table: sequence check failed");
`else
`define KVT_ASSERT(label, clk, rst, prop)
`define KVT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/kvt_pkg.sv -----
package kvt_pkg;

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 16;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam int ENTRIES_DEF   = 64;
  localparam int KEY_BITS_DEF  = 16;
  localparam int DATA_BITS_DEF = 32;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GET    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_MISS = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic scan_step;
    logic act;
    logic load_rsp;
  } ctrl_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic rsp_busy;
  } dp_sts_t;

endpackage

// ----- rtl/core/kvt_req_if.sv -----
interface kvt_req_if;
  logic                         valid;
  logic                         ready;
  logic [kvt_pkg::MODE_W-1:0]   mode;
  logic [kvt_pkg::KEY_W-1:0]    lookup_key;
  logic [kvt_pkg::DATA_W-1:0]   entry_data;

  modport source (output valid, mode, lookup_key, entry_data, input ready);
  modport sink   (input valid, mode, lookup_key, entry_data, output ready);
endinterface

// ----- rtl/core/kvt_rsp_if.sv -----
interface kvt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [kvt_pkg::STATUS_W-1:0]   status;
  logic [kvt_pkg::DATA_W-1:0]     found_data;
  logic [kvt_pkg::COUNT_W-1:0]    entry_count;

  modport source (output valid, status, found_data, entry_count, input ready);
  modport sink   (input valid, status, found_data, entry_count, output ready);
endinterface

// ----- rtl/core/kvt_ctrl.sv -----
module kvt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  kvt_pkg::dp_sts_t    sts,
  output kvt_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_ACT,
    S_RESULT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      req_ready <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (sts.idx_last) begin
            state     <= S_IDLE;
            req_ready <= 1'b1;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            state     <= S_SCAN;
            req_ready <= 1'b0;
          end
        end
        S_SCAN: begin
          if (sts.idx_last) begin
            state <= S_DRAIN;
          end
        end
        // last compare lands here
        S_DRAIN: begin
          state <= S_ACT;
        end
        S_ACT: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!sts.rsp_busy) begin
            state     <= S_IDLE;
            req_ready <= 1'b1;
          end
        end
        default: begin
          state     <= S_CLEAR;
          req_ready <= 1'b0;
        end
      endcase
    end
  end

  assign cmd.clear_step = (state == S_CLEAR);
  assign cmd.accept     = req_valid && req_ready;
  assign cmd.scan_step  = (state == S_SCAN);
  assign cmd.act        = (state == S_ACT);
  assign cmd.load_rsp   = (state == S_RESULT) && !sts.rsp_busy;

endmodule

// ----- rtl/core/kvt_datapath.sv -----
module kvt_datapath #(
  parameter int ENTRIES   = kvt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS  = kvt_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS = kvt_pkg::DATA_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  kvt_pkg::ctrl_cmd_t           cmd,
  output kvt_pkg::dp_sts_t             sts,
  input  logic [kvt_pkg::MODE_W-1:0]   mode,
  input  logic [kvt_pkg::KEY_W-1:0]    lookup_key,
  input  logic [kvt_pkg::DATA_W-1:0]   entry_data,
  kvt_rsp_if.source                    rsp
);

  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int OUT_DATA_W = kvt_pkg::DATA_W;
  localparam int OUT_CNT_W  = kvt_pkg::COUNT_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  // storage
  logic                 valid_mem [ENTRIES];
  logic [KEY_BITS-1:0]  key_mem   [ENTRIES];
  logic [DATA_BITS-1:0] data_mem  [ENTRIES];

  // captured request
  logic [kvt_pkg::MODE_W-1:0] mode_q;
  logic [KEY_BITS-1:0]        key_q;
  logic [DATA_BITS-1:0]       data_q;

  logic [IDX_W-1:0]     idx;
  logic                 cmp_vld;
  logic [IDX_W-1:0]     cmp_idx;
  logic                 valid_rd;
  logic [KEY_BITS-1:0]  key_rd;
  logic [DATA_BITS-1:0] data_rd;

  logic                 hit_found;
  logic [IDX_W-1:0]     hit_idx;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic [CNT_W-1:0]     count;

  logic                 ins_we;
  logic                 del_we;
  logic                 get_rd;
  logic                 vm_we;
  logic [IDX_W-1:0]     vm_addr;
  logic [kvt_pkg::STATUS_W-1:0] status_next;
  logic [OUT_DATA_W-1:0]        found_next;

  assign ins_we = cmd.act && (mode_q == kvt_pkg::MODE_INSERT) && !hit_found && free_found;
  assign del_we = cmd.act && (mode_q == kvt_pkg::MODE_DELETE) && hit_found;
  assign get_rd = cmd.act && (mode_q == kvt_pkg::MODE_GET) && hit_found;

  assign vm_we   = cmd.clear_step || ins_we || del_we;
  assign vm_addr = cmd.clear_step ? idx : (ins_we ? free_idx : hit_idx);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_q <= mode;
      key_q  <= KEY_BITS'(lookup_key);
      data_q <= DATA_BITS'(entry_data);
    end
  end

  // slot counter, shared by the clearing pass and the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.accept) begin
      idx <= '0;
    end else if (cmd.clear_step || cmd.scan_step) begin
      idx <= (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (vm_we) begin
      valid_mem[vm_addr] <= ins_we;
    end
    if (cmd.scan_step) begin
      valid_rd <= valid_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ins_we) begin
      key_mem[free_idx] <= key_q;
    end
    if (cmd.scan_step) begin
      key_rd <= key_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ins_we) begin
      data_mem[free_idx] <= data_q;
    end
    if (get_rd) begin
      data_rd <= data_mem[hit_idx];
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= idx;
    if (rst) begin
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_step;
    end
  end

  // first matching slot and first free slot, one slot a cycle
  always_ff @(posedge clk) begin
    if (rst || cmd.accept) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmp_vld) begin
      if (valid_rd && (key_rd == key_q) && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= cmp_idx;
      end
      if (!valid_rd && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ins_we) begin
      count <= count + CNT_W'(1);
    end else if (del_we) begin
      count <= count - CNT_W'(1);
    end
  end

  always_comb begin
    case (mode_q) inside
      kvt_pkg::MODE_INSERT: begin
        if (hit_found) begin
          status_next = kvt_pkg::ST_MISS;
        end else if (free_found) begin
          status_next = kvt_pkg::ST_DONE;
        end else begin
          status_next = kvt_pkg::ST_FULL;
        end
      end
      kvt_pkg::MODE_DELETE, kvt_pkg::MODE_GET: begin
        status_next = hit_found ? kvt_pkg::ST_DONE : kvt_pkg::ST_MISS;
      end
      default: begin
        status_next = kvt_pkg::ST_MISS;
      end
    endcase
  end

  assign found_next = ((mode_q == kvt_pkg::MODE_GET) && hit_found) ?
                      OUT_DATA_W'(data_rd) : '0;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.load_rsp) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rsp) begin
      rsp.status      <= status_next;
      rsp.found_data  <= found_next;
      rsp.entry_count <= OUT_CNT_W'(count);
    end
  end

  assign sts.idx_last = (idx == IDX_LAST);
  assign sts.rsp_busy = rsp.valid && !rsp.ready;

endmodule

// ----- rtl/core/key_value_table_top.sv -----
// Channel  Dir  Beat payload
// req      in   mode, lookup_key, entry_data
// rsp      out  status, found_data, entry_count
//
// Each request scans the slots one per cycle on the single read port of the
// key/valid memories, then passes through the last compare (S_DRAIN), the
// update or data fetch (S_ACT), the result load (S_RESULT) and the return
// to idle before the next beat; a stalled rsp holds it in S_RESULT.
// After reset the valid memory is cleared one slot a cycle, with req.ready low.
// A result waits in the output register while req takes the next beat; that
// request then holds before loading until rsp drains.
`include "key_value_table_top_defines.svh"

module key_value_table_top #(
  parameter int ENTRIES   = kvt_pkg::ENTRIES_DEF,
  parameter int KEY_BITS  = kvt_pkg::KEY_BITS_DEF,
  parameter int DATA_BITS = kvt_pkg::DATA_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  kvt_req_if.sink    req,
  kvt_rsp_if.source  rsp
);

  localparam int OUT_CNT_W = kvt_pkg::COUNT_W;

  kvt_pkg::ctrl_cmd_t cmd;
  kvt_pkg::dp_sts_t   sts;
  logic               full_beat;

  kvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kvt_datapath #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .mode       (req.mode),
    .lookup_key (req.lookup_key),
    .entry_data (req.entry_data),
    .rsp        (rsp)
  );

  assign full_beat = rsp.valid && (rsp.status == kvt_pkg::ST_FULL);

  `KVT_ASSERT(a_cmd_onehot, clk, rst, $onehot0(cmd))
  `KVT_ASSERT_NEXT(a_accept_starts_scan, clk, rst, cmd.accept, cmd.scan_step)
  `KVT_ASSERT_NEXT(a_load_shows_result, clk, rst, cmd.load_rsp, rsp.valid)
  `KVT_ASSERT(a_full_count, clk, rst, !full_beat || (rsp.entry_count == OUT_CNT_W'(ENTRIES)))

endmodule
